// ===== rtl/stun_brp_pkg.sv =====
// Shared types, constants and status codes for the STUN binding response parser.
// No dependencies; every other file in rtl/ imports this package.
package stun_brp_pkg;

	localparam int MAX_PACKET_DEF = 2048;

	// Width of a packet position: 20 plus a 16-bit declared length, plus padding slack
	localparam int POS_W     = 17;
	localparam int HDR_BYTES = 20;

	localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;
	localparam logic [15:0] MSG_BIND_RESP = 16'h0101;
	localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
	localparam logic [15:0] ATTR_MAPPED = 16'h0001;
	localparam logic [7:0]  FAMILY_V4 = 8'h01;
	localparam logic [7:0]  FAMILY_V6 = 8'h02;

	// Result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_SHORT      = 3'd1;
	localparam logic [2:0] ST_BAD_TYPE   = 3'd2;
	localparam logic [2:0] ST_BAD_COOKIE = 3'd3;
	localparam logic [2:0] ST_ID_MISMATCH = 3'd4;
	localparam logic [2:0] ST_OVERRUN    = 3'd5;
	localparam logic [2:0] ST_NO_ADDR    = 3'd6;

	// Configuration register indexes
	localparam logic CFG_TXID_HIGH = 1'b0;
	localparam logic CFG_TXID_LOW  = 1'b1;

	typedef struct packed {
		logic [15:0] decl;      // declared length as held now
		logic [15:0] decl_nxt;  // declared length after this byte
		logic [2:0]  fault_nxt; // first header fault after this byte
	} hdr_info_t;

	typedef struct packed {
		logic        found;
		logic        v6;
		logic [15:0] port;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        over;
	} walk_info_t;

endpackage

// ===== rtl/stun_binding_response_parser_unit.sv =====
// Top level of the STUN binding response parser: input register, header
// checker, attribute walker, status selection and result register.
// Depends on stun_brp_pkg, stun_brp_hdr and stun_brp_walk.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   in       | in_valid / in_stall    | data_byte, last_byte
//   out      | out_valid / out_stall  | status, is_ipv6, mapped_port, addr_high, addr_low
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte per cycle sustained. A byte is captured in the input register, is
// folded into the packet state as it leaves that register, and a last byte puts
// its result in the result register on the same edge that folds it. arst_n
// clears all control and packet state and the configured transaction ID. Only a
// last byte blocked behind an untaken result stalls the input; ordinary bytes
// keep flowing while a result waits.
module stun_binding_response_parser_unit #(
	parameter int MAX_PACKET = stun_brp_pkg::MAX_PACKET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        is_ipv6,
	output logic [15:0] mapped_port,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);
	import stun_brp_pkg::*;

	localparam int CNT_W = $clog2(MAX_PACKET + 1);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        step;
	logic [31:0] txid_high_q;
	logic [63:0] txid_low_q;

	logic [CNT_W-1:0] count;
	logic [CNT_W-1:0] count_nxt;
	logic             in_range;
	hdr_info_t        hdr;
	walk_info_t       walk;

	logic [2:0]  status_nxt;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        is_ipv6_q;
	logic [15:0] port_q;
	logic [63:0] addr_high_q;
	logic [63:0] addr_low_q;

	// Configuration: always ready; the user must write it only while the parser is idle, the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txid_high_q <= '0;
			txid_low_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TXID_HIGH: txid_high_q <= cfg_data[31:0];
				CFG_TXID_LOW:  txid_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the byte in the input register only when it is the last byte and the
	// previous result has not been taken yet.
	assign step     = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	stun_brp_hdr #(
		.MAX_PACKET (MAX_PACKET),
		.CNT_W      (CNT_W)
	) u_hdr (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.txid_high (txid_high_q),
		.txid_low  (txid_low_q),
		.count     (count),
		.count_nxt (count_nxt),
		.in_range  (in_range),
		.info      (hdr)
	);

	stun_brp_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_range  (in_range),
		.pos       (POS_W'(count)),
		.decl      (hdr.decl),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.txid_high (txid_high_q),
		.txid_low  (txid_low_q),
		.info      (walk)
	);

	// Status precedence, taken from the state as it stands after this byte:
	// short header, bad type, packet shorter than its declared length, other
	// header faults, then address found, overrun, no address.
	always_comb begin
		if (count_nxt < CNT_W'(HDR_BYTES))
			status_nxt = ST_SHORT;
		else if (hdr.fault_nxt == ST_BAD_TYPE)
			status_nxt = ST_BAD_TYPE;
		else if (POS_W'(HDR_BYTES) + POS_W'(hdr.decl_nxt) > POS_W'(count_nxt))
			status_nxt = ST_SHORT;
		else if (hdr.fault_nxt != ST_OK)
			status_nxt = hdr.fault_nxt;
		else if (walk.found)
			status_nxt = ST_OK;
		else if (walk.over)
			status_nxt = ST_OVERRUN;
		else
			status_nxt = ST_NO_ADDR;
	end

	// Result register: load on a last byte, drop the valid once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step && last_s1)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			status_q <= status_nxt;
			if (status_nxt == ST_OK) begin
				is_ipv6_q   <= walk.v6;
				port_q      <= walk.port;
				addr_high_q <= walk.hi;
				addr_low_q  <= walk.lo;
			end else begin
				is_ipv6_q   <= 1'b0;
				port_q      <= '0;
				addr_high_q <= '0;
				addr_low_q  <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign is_ipv6     = is_ipv6_q;
	assign mapped_port = port_q;
	assign addr_high   = addr_high_q;
	assign addr_low    = addr_low_q;

endmodule

// ===== rtl/stun_brp_hdr.sv =====
// Header checker: byte counter, declared length and first header fault.
// Depends on stun_brp_pkg.
module stun_brp_hdr #(
	parameter int MAX_PACKET = stun_brp_pkg::MAX_PACKET_DEF,
	parameter int CNT_W      = $clog2(MAX_PACKET + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	input  logic [31:0]                   txid_high,
	input  logic [63:0]                   txid_low,
	output logic [CNT_W-1:0]              count,
	output logic [CNT_W-1:0]              count_nxt,
	output logic                          in_range,
	output stun_brp_pkg::hdr_info_t       info
);
	import stun_brp_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [15:0]      decl_q;
	logic [2:0]       fault_q;
	logic [159:0]     hdr_ref;
	logic [4:0]       pos5;
	logic [4:0]       ref_idx;
	logic [7:0]       exp_byte;
	logic [15:0]      decl_nxt;
	logic [2:0]       fault_nxt;

	assign hdr_ref  = {MSG_BIND_RESP, 16'h0000, MAGIC_COOKIE, txid_high, txid_low};
	assign pos5     = count_q[4:0];
	assign ref_idx  = 5'(HDR_BYTES - 1) - pos5;
	assign exp_byte = 8'(hdr_ref >> {ref_idx, 3'b000});
	assign in_range = count_q < CNT_W'(MAX_PACKET);
	assign count_nxt = in_range ? count_q + CNT_W'(1) : count_q;

	always_comb begin
		decl_nxt  = decl_q;
		fault_nxt = fault_q;
		if (in_range && count_q < CNT_W'(HDR_BYTES)) begin
			if (pos5 == 5'd2) begin
				decl_nxt = {data_byte, 8'h00};
			end else if (pos5 == 5'd3) begin
				decl_nxt = {decl_q[15:8], data_byte};
			end else if (data_byte != exp_byte && fault_q == ST_OK) begin
				if (pos5 < 5'd2)
					fault_nxt = ST_BAD_TYPE;
				else if (pos5 < 5'd8)
					fault_nxt = ST_BAD_COOKIE;
				else
					fault_nxt = ST_ID_MISMATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			decl_q  <= '0;
			fault_q <= ST_OK;
		end else if (step) begin
			if (last_byte) begin
				count_q <= '0;
				decl_q  <= '0;
				fault_q <= ST_OK;
			end else begin
				count_q <= count_nxt;
				decl_q  <= decl_nxt;
				fault_q <= fault_nxt;
			end
		end
	end

	assign count          = count_q;
	assign info.decl      = decl_q;
	assign info.decl_nxt  = decl_nxt;
	assign info.fault_nxt = fault_nxt;

endmodule

// ===== rtl/stun_brp_walk.sv =====
// Attribute walker: TLV framing with 4-byte padding and mapped address decode.
// Depends on stun_brp_pkg.
module stun_brp_walk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              in_range,
	input  logic [stun_brp_pkg::POS_W-1:0]    pos,
	input  logic [15:0]                       decl,
	input  logic [7:0]                        data_byte,
	input  logic                              last_byte,
	input  logic [31:0]                       txid_high,
	input  logic [63:0]                       txid_low,
	output stun_brp_pkg::walk_info_t          info
);
	import stun_brp_pkg::*;

	logic [POS_W-1:0] start_q, start_nxt;
	logic [15:0]      kind_q, kind_nxt;
	logic [15:0]      len_q, len_nxt;
	logic [7:0]       vb_q [HDR_BYTES];
	logic [7:0]       vb_m [HDR_BYTES];
	walk_info_t       cur_q, nxt;

	logic [POS_W-1:0] end_pos;
	logic [POS_W:0]   hdr_end;
	logic [POS_W:0]   rec_end;
	logic [POS_W-1:0] rel;
	logic [15:0]      len_full;
	logic [15:0]      len_eff;
	logic             active;
	logic             store;
	logic [4:0]       vb_idx;
	logic             finish;
	logic             is_xor;
	logic             dec_ok;
	logic             dec_v6;
	logic [15:0]      dec_port;
	logic [63:0]      dec_hi, dec_lo;

	assign end_pos  = POS_W'(HDR_BYTES) + POS_W'(decl);
	assign hdr_end  = (POS_W+1)'(start_q) + (POS_W+1)'(4);
	assign rel      = pos - start_q;
	assign len_full = {len_q[15:8], data_byte};
	assign active   = in_range && !cur_q.found && !cur_q.over && pos < end_pos &&
		pos >= start_q && hdr_end <= (POS_W+1)'(end_pos);
	assign store    = active && rel >= POS_W'(4) && rel < POS_W'(4 + HDR_BYTES);
	assign vb_idx   = 5'(rel - POS_W'(4));
	assign len_eff  = (rel == POS_W'(3)) ? len_full : len_q;
	assign rec_end  = hdr_end + (POS_W+1)'(len_eff);

	// Value bytes as they stand once this byte is written
	always_comb begin
		for (int i = 0; i < HDR_BYTES; i++)
			vb_m[i] = (store && vb_idx == 5'(i)) ? data_byte : vb_q[i];
	end

	// Mapped address decode of the attribute that ends with this byte
	always_comb begin
		is_xor   = kind_q == ATTR_XOR_MAPPED;
		dec_ok   = 1'b0;
		dec_v6   = 1'b0;
		dec_port = {vb_m[2], vb_m[3]} ^ (is_xor ? MAGIC_COOKIE[31:16] : 16'h0000);
		dec_hi   = '0;
		dec_lo   = {32'h0, {vb_m[4], vb_m[5], vb_m[6], vb_m[7]} ^
			(is_xor ? MAGIC_COOKIE : 32'h0)};
		if ((is_xor || kind_q == ATTR_MAPPED) && len_eff >= 16'd4) begin
			if (vb_m[1] == FAMILY_V4) begin
				dec_ok = len_eff >= 16'd8;
			end else if (vb_m[1] == FAMILY_V6) begin
				dec_ok = len_eff >= 16'd20;
				dec_v6 = 1'b1;
				dec_hi = {vb_m[4], vb_m[5], vb_m[6], vb_m[7],
					vb_m[8], vb_m[9], vb_m[10], vb_m[11]} ^
					(is_xor ? {MAGIC_COOKIE, txid_high} : 64'h0);
				dec_lo = {vb_m[12], vb_m[13], vb_m[14], vb_m[15],
					vb_m[16], vb_m[17], vb_m[18], vb_m[19]} ^
					(is_xor ? txid_low : 64'h0);
			end
		end
	end

	always_comb begin
		nxt       = cur_q;
		start_nxt = start_q;
		kind_nxt  = kind_q;
		len_nxt   = len_q;
		finish    = 1'b0;
		if (active) begin
			case (rel)
				POS_W'(0): kind_nxt = {data_byte, 8'h00};
				POS_W'(1): kind_nxt = {kind_q[15:8], data_byte};
				POS_W'(2): len_nxt  = {data_byte, 8'h00};
				POS_W'(3): begin
					len_nxt = len_full;
					if (rec_end > (POS_W+1)'(end_pos))
						nxt.over = 1'b1;
					else
						finish = len_full == 16'h0000;
				end
				default: finish = (rel - POS_W'(3)) == POS_W'(len_q);
			endcase
		end
		if (finish) begin
			if (dec_ok) begin
				nxt.found = 1'b1;
				nxt.v6    = dec_v6;
				nxt.port  = dec_port;
				nxt.hi    = dec_hi;
				nxt.lo    = dec_lo;
			end else begin
				// advance to the next record, rounded up to a 4-byte boundary
				start_nxt = POS_W'((rec_end + (POS_W+1)'(3)) & ~(POS_W+1)'(3));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= POS_W'(HDR_BYTES);
			kind_q  <= '0;
			len_q   <= '0;
			cur_q   <= '0;
		end else if (step) begin
			if (last_byte) begin
				start_q <= POS_W'(HDR_BYTES);
				kind_q  <= '0;
				len_q   <= '0;
				cur_q   <= '0;
			end else begin
				start_q <= start_nxt;
				kind_q  <= kind_nxt;
				len_q   <= len_nxt;
				cur_q   <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && store)
			vb_q[vb_idx] <= data_byte;
	end

	assign info = nxt;

endmodule
